### sv/isrt_pkg.sv
// shared types and constants for the insertion sorter
package isrt_pkg;

    // number of cells in the sorting chain
    localparam int unsigned MaxElements = 32;

    // element width
    localparam int unsigned ValueW = 32;

    // sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [ValueW-1:0] ins_value;
    } cell_ctrl_t;

    // what one cell shows its neighbours
    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic signed [ValueW-1:0] value;
    } cell_out_t;

endpackage

### sv/insertion_sorter.sv
// top level of the insertion sorter: cell chain and batch sequencer
// Values enter one per cycle on the s_ channel while s_tready is high and are placed
// into a sorted chain of 32 cells, each cell comparing against the new value in
// parallel. Equal values keep their arrival order. Once a transaction with s_tlast
// has been inserted, s_tready drops and the chain drains from its lowest cell, one
// result per cycle while m_tready is high; m_tlast marks the final result and m_tuser
// flags a batch in which values arriving at a full chain were discarded. Input is
// taken again after the final result has gone.
module insertion_sorter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] overflow
);

    localparam int unsigned Depth = isrt_pkg::MaxElements;

    isrt_pkg::state_t     state_reg;
    isrt_pkg::state_t     state_next;
    logic                 dropped_reg;
    logic                 dropped_next;
    isrt_pkg::cell_ctrl_t ctrl;
    isrt_pkg::cell_out_t  cells [Depth];
    isrt_pkg::cell_out_t  edge_left;
    isrt_pkg::cell_out_t  edge_right;
    logic                 s_accept;
    logic                 m_accept;
    logic                 full;

    // handshakes
    assign s_tready = (state_reg == isrt_pkg::ST_FILL);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == isrt_pkg::ST_DRAIN) && cells[0].valid;
    assign m_accept = m_tvalid && m_tready;
    assign full     = cells[Depth-1].valid;

    // broadcast control
    assign ctrl.insert    = s_accept && !full;
    assign ctrl.shift     = m_accept;
    assign ctrl.ins_value = $signed(s_tdata);

    // chain ends: cell zero takes the new value whenever its entry moves up, the top pulls in nothing
    assign edge_left.valid  = 1'b1;
    assign edge_left.gt     = 1'b0;
    assign edge_left.value  = '0;
    assign edge_right.valid = 1'b0;
    assign edge_right.gt    = 1'b1;
    assign edge_right.value = '0;

    // the cell chain
    for (genvar i = 0; i < Depth; i++) begin : g_cell
        isrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .left_in  ((i == 0) ? edge_left : cells[(i == 0) ? 0 : i-1]),
            .right_in ((i == Depth-1) ? edge_right : cells[(i == Depth-1) ? i : i+1]),
            .cell_out (cells[i])
        );
    end

    // sequencer and overflow flag
    always_comb begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            isrt_pkg::ST_FILL: begin
                if (s_accept && full) begin
                    dropped_next = 1'b1;
                end
                if (s_accept && s_tlast) begin
                    state_next = isrt_pkg::ST_DRAIN;
                end
            end
            isrt_pkg::ST_DRAIN: begin
                if (m_accept && m_tlast) begin
                    state_next   = isrt_pkg::ST_FILL;
                    dropped_next = 1'b0;
                end
            end
            default: begin
                state_next   = isrt_pkg::ST_FILL;
                dropped_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= isrt_pkg::ST_FILL;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    // result from the lowest cell
    assign m_tdata    = cells[0].value;
    assign m_tlast    = !cells[1].valid;
    assign m_tuser[0] = dropped_reg;

    // a drain always has an entry at the bottom of the chain
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == isrt_pkg::ST_DRAIN |-> cells[0].valid)
        else $error("drain with empty chain");

    // input and output never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("both channels active");

    // final result empties the chain
    a_final_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && m_tlast |=> !cells[0].valid && !dropped_reg)
        else $error("chain not empty after final result");

    // an item that is not last keeps the block filling
    a_fill_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_tlast |=> state_reg == isrt_pkg::ST_FILL)
        else $error("left fill without last");

endmodule

### sv/isrt_cell.sv
// one storage cell of the insertion chain
module isrt_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  isrt_pkg::cell_ctrl_t  ctrl,
    input  isrt_pkg::cell_out_t   left_in,
    input  isrt_pkg::cell_out_t   right_in,
    output isrt_pkg::cell_out_t   cell_out
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [isrt_pkg::ValueW-1:0] value_reg;
    logic signed [isrt_pkg::ValueW-1:0] value_next;
    logic                              gt;

    // an empty cell counts as larger than any value
    assign gt = !valid_reg || (value_reg > ctrl.ins_value);

    // insert moves larger entries up one place, shift drains towards cell zero
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert) begin
            if (gt) begin
                if (left_in.gt) begin
                    valid_next = left_in.valid;
                    value_next = left_in.value;
                end else begin
                    valid_next = 1'b1;
                    value_next = ctrl.ins_value;
                end
            end
        end else if (ctrl.shift) begin
            valid_next = right_in.valid;
            value_next = right_in.value;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // stored element
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.gt    = gt;
    assign cell_out.value = value_reg;

endmodule

### dv/isrt_checker.sv
// checker for the insertion sorter: predicts sorted batches and compares results
`timescale 1ns / 1ps

module isrt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] sorted_value
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser,   // [0] overflow
    output int          errors,
    output int          pending
);

    // one predicted output transaction
    typedef struct packed {
        logic signed [isrt_pkg::ValueW-1:0] value;
        logic                               last;
        logic                               overflow;
    } sorted_item_t;

    // predicted contents of the sorting chain
    logic signed [isrt_pkg::ValueW-1:0] chain [isrt_pkg::MaxElements];
    int unsigned                        held = 0;
    logic                               lost = 1'b0;

    // predicted results still to come, oldest first
    sorted_item_t sorted_due [$];

    int err_count     = 0;
    int pending_count = 0;

    assign errors  = err_count;
    assign pending = pending_count;

    // place one value into the chain; on tlast emit the whole batch
    task automatic insert_value(input logic signed [isrt_pkg::ValueW-1:0] v, input logic l);
        int           pos;
        sorted_item_t r;
        if (held < isrt_pkg::MaxElements) begin
            pos = held;
            // larger entries move up, equal ones stay below the newcomer
            while (pos > 0 && v < chain[pos-1]) begin
                chain[pos] = chain[pos-1];
                pos--;
            end
            chain[pos] = v;
            held++;
        end else begin
            lost = 1'b1;
        end
        if (l) begin
            for (int k = 0; k < held; k++) begin
                r.value    = chain[k];
                r.last     = (k + 1 == held);
                r.overflow = lost;
                sorted_due = {sorted_due, r};
            end
            held = 0;
            lost = 1'b0;
        end
    endtask

    // compare one output transaction with the oldest prediction
    task automatic check_sorted(input logic [31:0] d, input logic l, input logic o);
        sorted_item_t r;
        if (sorted_due.size() == 0) begin
            $display("%0t: unexpected result value=%0d last=%0b overflow=%0b",
                     $time, $signed(d), l, o);
            err_count++;
        end else begin
            r = sorted_due.pop_front();
            if (d !== r.value) begin
                $display("%0t: sorted_value expected %0d actual %0d",
                         $time, r.value, $signed(d));
                err_count++;
            end
            if (l !== r.last) begin
                $display("%0t: last_out expected %0b actual %0b", $time, r.last, l);
                err_count++;
            end
            if (o !== r.overflow) begin
                $display("%0t: overflow expected %0b actual %0b", $time, r.overflow, o);
                err_count++;
            end
        end
    endtask

    // watch both channels at every edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                insert_value(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_sorted(m_tdata, m_tlast, m_tuser[0]);
            end
        end
        pending_count = sorted_due.size();
    end

endmodule

### dv/testbench.sv
// testbench top for the insertion sorter: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module testbench;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] sorted_value
    logic        m_tlast;
    logic [0:0]  m_tuser;   // [0] overflow

    int errors;
    int pending;
    int sent = 0;

    insertion_sorter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    isrt_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int stall_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // element value for a batch of the given flavour
    function automatic logic [31:0] pick_value(input int flavour);
        case (flavour)
            0: return $urandom();
            1: return $signed($urandom_range(0, 8)) - 4;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    default: return $urandom();
                endcase
            end
            default: return {{16{1'b0}}, 16'($urandom())} ^ {32{$urandom_range(0, 1) == 1}};
        endcase
    endfunction

    // hold one transaction until it is taken, then idle if asked
    task automatic send_value(input logic [31:0] v, input logic l, input int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold-off until every predicted result has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // receiver: runs of ready with random stalls, and some long stall-free stretches
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(100, 200)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_tready <= 1'b0;
                repeat (stall_len() + 1) @(posedge aclk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int len;
        int flavour;
        int batches;
        bit no_gaps;
        logic [31:0] v;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-entry batches at both extremes
        send_value(32'h7fff_ffff, 1'b1, 0);
        send_value(32'h8000_0000, 1'b1, stall_len());
        // mixed extremes with equal values
        send_value(32'h0000_0000, 1'b0, 0);
        send_value(32'hffff_ffff, 1'b0, stall_len());
        send_value(32'h0000_0001, 1'b0, 0);
        send_value(32'h7fff_ffff, 1'b0, 0);
        send_value(32'h8000_0000, 1'b0, stall_len());
        send_value(32'd5,         1'b0, 0);
        send_value(32'd5,         1'b0, 0);
        send_value(-32'sd5,       1'b0, 0);
        send_value(32'd5,         1'b1, 0);
        // descending then ascending runs
        send_value(32'd4, 1'b0, 0);
        send_value(32'd3, 1'b0, 0);
        send_value(32'd2, 1'b0, 0);
        send_value(32'd1, 1'b1, 0);
        send_value(32'd10, 1'b0, 0);
        send_value(32'd20, 1'b0, 0);
        send_value(32'd30, 1'b1, 0);

        // sender hold-off until the chain has emptied
        wait_drained();

        // random batches: mostly short, some long, a few past the chain size
        batches = 0;
        while (sent < 520) begin
            case ($urandom_range(0, 19))
                0, 1:       len = $urandom_range(isrt_pkg::MaxElements - 2,
                                                 isrt_pkg::MaxElements + 8);
                2, 3, 4:    len = $urandom_range(9, isrt_pkg::MaxElements - 3);
                default:    len = $urandom_range(1, 8);
            endcase
            flavour = $urandom_range(0, 3);
            no_gaps = ($urandom_range(0, 9) < 3);
            v = pick_value(flavour);
            for (int i = 0; i < len; i++) begin
                // flavour three walks up or down from a random start
                if (flavour == 3) v = v + (($urandom_range(0, 1) == 1) ? 1 : -1);
                else v = pick_value(flavour);
                send_value(v, i == len - 1, no_gaps ? 0 : stall_len());
            end
            batches++;
            if (batches == 40) wait_drained();
        end

        // drain and let any stray result show up
        wait_drained();
        repeat (64) @(posedge aclk);

        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
